### hw/rtl/csht_pkg.sv
`timescale 1ns / 1ps
package csht_pkg;

  localparam int KEY_W   = 64;
  localparam int HALF_W  = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 14;
  localparam int CFG_W   = 11;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    FN_LOOKUP = 1'b0,
    FN_INSERT = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HREAD,
    S_HCHK,
    S_PCHK,
    S_PNEW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    clr_step;
    logic    bucket_ld;
    logic    pool_rd;
    logic    pool_from_head;
    logic    head_wr_kv;
    logic    head_wr_link;
    logic    pool_wr_tail;
    logic    pool_wr_new;
    logic    free_dec;
    logic    count_inc;
    logic    res_set;
    status_t res_status;
    logic    res_from_head;
    logic    res_from_pool;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  cfg_wr;
    logic  mod_done;
    logic  clr_last;
    func_t func;
    logic  head_key_zero;
    logic  head_match;
    logic  head_link_zero;
    logic  pool_match;
    logic  pool_link_zero;
    logic  free_zero;
    logic  out_free;
  } dp_stat_t;

endpackage

### hw/rtl/csht_mod.sv
`timescale 1ns / 1ps
module csht_mod #(
  parameter int BW = 11,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [BW-1:0] divisor,
  output logic          done,
  output logic [AW-1:0] rem
);

  logic [31:0]   dvd_r, dvd_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [BW:0]   trial;

  assign trial = {rem_r, dvd_r[31]};
  assign done  = busy_r && (cnt_r == 6'd0);
  assign rem   = rem_r[AW-1:0];

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
      end else begin
        dvd_nxt = {dvd_r[30:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = BW'(trial - {1'b0, divisor});
        end else begin
          rem_nxt = BW'(trial);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

endmodule

### hw/rtl/csht_dp.sv
`timescale 1ns / 1ps
module csht_dp #(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_FACTOR = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csht_pkg::ctrl_cmd_t       cmd,
  output csht_pkg::dp_stat_t        stat,
  input  logic                      in_func,
  input  logic [31:0]               in_key_low,
  input  logic [31:0]               in_key_high,
  input  logic [31:0]               in_value,
  input  logic                      cfg_wr,
  input  logic [10:0]               cfg_value,
  input  logic                      out_ready,
  output logic                      out_valid,
  output csht_pkg::status_t         out_status,
  output logic [31:0]               out_value,
  output logic [13:0]               out_count
);
  import csht_pkg::*;

  localparam int POOL_SIZE = POOL_FACTOR * MAX_BUCKETS;
  localparam int BW = $clog2(MAX_BUCKETS + 1);
  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int LW = $clog2(POOL_SIZE + 1);

  logic [KEY_W-1:0] head_key_mem [MAX_BUCKETS];
  logic [VAL_W-1:0] head_val_mem [MAX_BUCKETS];
  logic [LW-1:0]    head_link_mem[MAX_BUCKETS];
  logic [KEY_W-1:0] pool_key_mem [POOL_SIZE];
  logic [VAL_W-1:0] pool_val_mem [POOL_SIZE];
  logic [LW-1:0]    pool_link_mem[POOL_SIZE];

  logic [KEY_W-1:0] head_key_rd_r, pool_key_rd_r;
  logic [VAL_W-1:0] head_val_rd_r, pool_val_rd_r;
  logic [LW-1:0]    head_link_rd_r, pool_link_rd_r;

  logic [BW-1:0]    bc_r;
  logic [LW-1:0]    free_r;
  logic [CNT_W-1:0] count_r;
  logic [AW-1:0]    clr_r;
  logic [AW-1:0]    bucket_r;
  logic [PW-1:0]    pidx_r;
  func_t            func_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  status_t          res_status_r;
  logic [VAL_W-1:0] res_val_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [VAL_W-1:0] out_value_r;
  logic [CNT_W-1:0] out_count_r;

  logic [31:0]      bc_clamp;
  logic [BW-1:0]    bc_new;
  logic [AW-1:0]    head_addr;
  logic [PW-1:0]    pool_raddr;
  logic [PW-1:0]    new_idx;
  logic             mod_done;
  logic [AW-1:0]    mod_rem;

  always_comb begin
    bc_clamp = {21'd0, cfg_value};
    if (bc_clamp == 32'd0) begin
      bc_clamp = 32'd1;
    end
    if (bc_clamp > 32'(MAX_BUCKETS)) begin
      bc_clamp = 32'(MAX_BUCKETS);
    end
  end
  assign bc_new = BW'(bc_clamp);

  csht_mod #(.BW(BW), .AW(AW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (in_key_low + in_key_high),
    .divisor  (bc_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign head_addr  = cmd.clr_step ? clr_r : bucket_r;
  assign pool_raddr = cmd.pool_from_head ? PW'(head_link_rd_r - LW'(1))
                                         : PW'(pool_link_rd_r - LW'(1));
  assign new_idx    = PW'(free_r - LW'(1));

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      head_key_mem[head_addr]  <= '0;
      head_val_mem[head_addr]  <= '0;
      head_link_mem[head_addr] <= '0;
    end else begin
      if (cmd.head_wr_kv) begin
        head_key_mem[head_addr] <= key_r;
        head_val_mem[head_addr] <= val_r;
      end
      if (cmd.head_wr_link) begin
        head_link_mem[head_addr] <= free_r;
      end
    end
    head_key_rd_r  <= head_key_mem[head_addr];
    head_val_rd_r  <= head_val_mem[head_addr];
    head_link_rd_r <= head_link_mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.pool_wr_new) begin
      pool_key_mem[new_idx]  <= key_r;
      pool_val_mem[new_idx]  <= val_r;
      pool_link_mem[new_idx] <= '0;
    end else if (cmd.pool_wr_tail) begin
      pool_link_mem[pidx_r] <= free_r;
    end
    pool_key_rd_r  <= pool_key_mem[pool_raddr];
    pool_val_rd_r  <= pool_val_mem[pool_raddr];
    pool_link_rd_r <= pool_link_mem[pool_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r        <= BW'(MAX_BUCKETS);
      free_r      <= LW'(POOL_SIZE);
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        bc_r    <= bc_new;
        free_r  <= LW'(32'(POOL_FACTOR) * 32'(bc_new));
        count_r <= '0;
        clr_r   <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_r <= clr_r + AW'(1);
        end
        if (cmd.free_dec) begin
          free_r <= free_r - LW'(1);
        end
        if (cmd.count_inc && count_r != COUNT_MAX) begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_t'(in_func);
      key_r  <= {in_key_high, in_key_low};
      val_r  <= in_value;
    end
    if (cmd.bucket_ld) begin
      bucket_r <= mod_rem;
    end
    if (cmd.pool_rd) begin
      pidx_r <= pool_raddr;
    end
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      if (cmd.res_from_head) begin
        res_val_r <= head_val_rd_r;
      end else if (cmd.res_from_pool) begin
        res_val_r <= pool_val_rd_r;
      end else begin
        res_val_r <= '0;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_val_r;
      out_count_r  <= count_r;
    end
  end

  assign stat.cfg_wr         = cfg_wr;
  assign stat.mod_done       = mod_done;
  assign stat.clr_last       = (clr_r == AW'(MAX_BUCKETS - 1));
  assign stat.func           = func_r;
  assign stat.head_key_zero  = (head_key_rd_r == '0);
  assign stat.head_match     = (head_key_rd_r == key_r);
  assign stat.head_link_zero = (head_link_rd_r == '0);
  assign stat.pool_match     = (pool_key_rd_r == key_r);
  assign stat.pool_link_zero = (pool_link_rd_r == '0);
  assign stat.free_zero      = (free_r == '0);
  assign stat.out_free       = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;

endmodule

### hw/rtl/csht_ctrl.sv
`timescale 1ns / 1ps
module csht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cfg_pending,
  input  csht_pkg::dp_stat_t  stat,
  output csht_pkg::ctrl_cmd_t cmd
);
  import csht_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    in_ready       = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = !cfg_pending;
        if (in_valid && !cfg_pending) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.mod_done) begin
          cmd.bucket_ld = 1'b1;
          state_nxt     = S_HREAD;
        end
      end
      S_HREAD: begin
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (stat.func == FN_LOOKUP) begin
          if (stat.head_match) begin
            cmd.res_set       = 1'b1;
            cmd.res_from_head = 1'b1;
            state_nxt         = S_DONE;
          end else if (stat.head_link_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_MISS;
            state_nxt      = S_DONE;
          end else begin
            cmd.pool_rd        = 1'b1;
            cmd.pool_from_head = 1'b1;
            state_nxt          = S_PCHK;
          end
        end else begin
          if (stat.head_key_zero) begin
            cmd.head_wr_kv = 1'b1;
            cmd.count_inc  = 1'b1;
            cmd.res_set    = 1'b1;
            state_nxt      = S_DONE;
          end else if (stat.free_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_FULL;
            state_nxt      = S_DONE;
          end else if (stat.head_link_zero) begin
            cmd.head_wr_link = 1'b1;
            cmd.pool_wr_new  = 1'b1;
            cmd.free_dec     = 1'b1;
            cmd.count_inc    = 1'b1;
            cmd.res_set      = 1'b1;
            state_nxt        = S_DONE;
          end else begin
            cmd.pool_rd        = 1'b1;
            cmd.pool_from_head = 1'b1;
            state_nxt          = S_PCHK;
          end
        end
      end
      S_PCHK: begin
        if (stat.func == FN_LOOKUP && stat.pool_match) begin
          cmd.res_set       = 1'b1;
          cmd.res_from_pool = 1'b1;
          state_nxt         = S_DONE;
        end else if (stat.pool_link_zero) begin
          if (stat.func == FN_LOOKUP) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_MISS;
            state_nxt      = S_DONE;
          end else begin
            cmd.pool_wr_tail = 1'b1;
            state_nxt        = S_PNEW;
          end
        end else begin
          cmd.pool_rd = 1'b1;
        end
      end
      S_PNEW: begin
        cmd.pool_wr_new = 1'b1;
        cmd.free_dec    = 1'b1;
        cmd.count_inc   = 1'b1;
        cmd.res_set     = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    if (stat.cfg_wr) begin
      state_nxt = S_CLEAR;
    end
  end

endmodule

### hw/rtl/chained_signature_hash_table_top.sv
`timescale 1ns / 1ps
// A request is taken only in idle and passes the 32-step remainder unit, the head read and
// check, and a one-node-per-cycle chain walk over the pool memory (plus a tail append on
// insert); the next request is not taken until the result has been handed to the output.
// Reset (rst_n, synchronous) and every bucket_count write start a clearing pass over
// all MAX_BUCKETS bucket heads; no request is taken during it.
module chained_signature_hash_table_top #(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_FACTOR = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // key_low, key_high, insert_value
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // found_value, entry_count, zero pad
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data    // bucket_count
);
  import csht_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  status_t          res_status;
  logic [VAL_W-1:0] res_value;
  logic [CNT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  csht_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cfg_pending (cfg_valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  csht_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_FACTOR (POOL_FACTOR)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (in_tuser),
    .in_key_low  (in_tdata[31:0]),
    .in_key_high (in_tdata[63:32]),
    .in_value    (in_tdata[95:64]),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_value   (cfg_data),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (res_status),
    .out_value   (res_value),
    .out_count   (res_count)
  );

  assign out_tdata = {2'b00, res_count, res_value};
  assign out_tuser = res_status;

endmodule
